### rtl/gjsd_pkg.sv
// Shared types and constants for the greedy job-shop dispatcher.
// No dependencies.
package gjsd_pkg;

    localparam int MAX_JOBS        = 16;
    localparam int MAX_OPS_PER_JOB = 16;
    localparam int MAX_MACHINES    = 16;
    localparam int TIME_WIDTH      = 24;
    localparam int SUM_WIDTH       = 28;
    localparam int JOB_W           = 4;
    localparam int MACH_W          = 4;
    localparam int DUR_W           = 16;
    localparam int OPC_W           = 5;   // holds 0..MAX_OPS_PER_JOB
    localparam int SLOT_W          = 8;   // job and op-within-job index
    localparam int CFG_W           = 5;
    localparam int CFG_IDX_W       = 1;

    localparam logic [CFG_IDX_W-1:0] REG_JOB_COUNT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MACHINE_COUNT = 1'b1;

    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};
    localparam logic [SUM_WIDTH-1:0]  SUM_MAX  = {SUM_WIDTH{1'b1}};

    typedef struct packed {
        logic [JOB_W-1:0]  job_id;
        logic [MACH_W-1:0] machine_id;
        logic [DUR_W-1:0]  duration;
        logic              last_op;
    } op_in_t;

    typedef struct packed {
        logic [SUM_WIDTH-1:0] total_completion;
        logic                 dropped;
    } result_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_EVAL,
        ST_COMMIT,
        ST_SUM,
        ST_OUT
    } state_t;

endpackage

### rtl/gjsd_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module gjsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/greedy_job_shop_dispatcher.sv
// Greedy job-shop dispatcher top level: loader, dispatch sequencer, operation store.
// Depends on gjsd_pkg and gjsd_ram.
//
// Usage: each beat on the input channel (in_valid/in_ready, payload in) carries
// one operation of a job. Operations are stored in two 256-entry RAMs (machine
// and duration), one entry per job and slot; load beats may follow back to back.
// A beat with last_op set starts dispatch: each dispatch step scans the jobs
// through the RAM read port, a read state per job and an evaluate state for each
// job with an operation left, then an end-of-scan check and a commit. A final
// empty scan ends dispatch and the job finish times are summed. The single
// result beat (out_valid/out_ready, payload out) waits in an output register;
// while it is not taken no new item is accepted, and loading resumes once
// out_valid has dropped and the state has returned to load. Reset clears
// counters, times and the drop flag and sets both counts to 16; RAM contents
// stay undefined and are only used below the per-job fill count. Registers
// must be written through cfg_we/cfg_index/cfg_data while idle; the block does
// not enforce this. Values above 16 act as 16. State clears after each result.
module greedy_job_shop_dispatcher
    import gjsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  op_in_t               in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output result_t              out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    state_t state_reg, state_next;
    logic [CFG_W-1:0] job_count_reg, machine_count_reg;
    logic [OPC_W-1:0] ops_loaded_reg [MAX_JOBS];
    logic [OPC_W-1:0] next_op_reg [MAX_JOBS];
    logic [TIME_WIDTH-1:0] job_finish_reg [MAX_JOBS];
    logic [TIME_WIDTH-1:0] machine_free_reg [MAX_MACHINES];
    logic drop_reg;
    logic [JOB_W:0] scan_reg, scan_next;
    logic found_reg;
    logic [TIME_WIDTH-1:0] best_reg;
    logic [JOB_W-1:0] best_job_reg;
    logic [MACH_W-1:0] best_mach_reg;
    logic [SUM_WIDTH-1:0] sum_reg;
    result_t out_reg;
    logic out_valid_reg;

    logic [CFG_W-1:0] eff_jobs, eff_machs;
    logic ram_we;
    logic [SLOT_W-1:0] ram_addr;
    logic [MACH_W-1:0] rd_mach;
    logic [DUR_W-1:0] rd_dur;
    logic in_fire, load_ok;
    logic [JOB_W-1:0] sj;
    logic [TIME_WIDTH-1:0] start_t;
    logic [TIME_WIDTH:0] fin_wide;
    logic [TIME_WIDTH-1:0] fin;
    logic has_op;
    logic [SUM_WIDTH:0] sum_wide;

    assign eff_jobs  = (job_count_reg > CFG_W'(MAX_JOBS)) ? CFG_W'(MAX_JOBS) : job_count_reg;
    assign eff_machs = (machine_count_reg > CFG_W'(MAX_MACHINES))
                       ? CFG_W'(MAX_MACHINES) : machine_count_reg;

    assign in_ready = (state_reg == ST_LOAD) && !out_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign load_ok  = ({1'b0, in.job_id} < eff_jobs) && ({1'b0, in.machine_id} < eff_machs)
                      && (ops_loaded_reg[in.job_id] < OPC_W'(MAX_OPS_PER_JOB));
    assign sj       = scan_reg[JOB_W-1:0];
    assign has_op   = next_op_reg[sj] < ops_loaded_reg[sj];

    gjsd_ram #(.WIDTH(MACH_W), .DEPTH(MAX_JOBS*MAX_OPS_PER_JOB)) u_mach_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in.machine_id), .rdata(rd_mach));
    gjsd_ram #(.WIDTH(DUR_W), .DEPTH(MAX_JOBS*MAX_OPS_PER_JOB)) u_dur_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in.duration), .rdata(rd_dur));

    always_comb
    begin
        ram_we = in_fire && load_ok;
        if (state_reg == ST_LOAD)
        begin
            ram_addr = {in.job_id, ops_loaded_reg[in.job_id][JOB_W-1:0]};
        end
        else
        begin
            ram_addr = {sj, next_op_reg[sj][JOB_W-1:0]};
        end
    end

    // finish time of the scanned job, saturated
    always_comb
    begin
        start_t  = (machine_free_reg[rd_mach] > job_finish_reg[sj])
                   ? machine_free_reg[rd_mach] : job_finish_reg[sj];
        fin_wide = {1'b0, start_t} + (TIME_WIDTH+1)'(rd_dur);
        fin      = fin_wide[TIME_WIDTH] ? TIME_MAX : fin_wide[TIME_WIDTH-1:0];
        sum_wide = {1'b0, sum_reg} + (SUM_WIDTH+1)'(job_finish_reg[sj]);
    end

    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        case (state_reg)
            ST_LOAD:
            begin
                scan_next = '0;
                if (in_fire && in.last_op)
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                if (scan_reg >= (JOB_W+1)'(eff_jobs))
                begin
                    state_next = found_reg ? ST_COMMIT : ST_SUM;
                    scan_next  = '0;
                end
                else if (has_op)
                begin
                    state_next = ST_SCAN_EVAL;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_SCAN_EVAL:
            begin
                state_next = ST_SCAN_RD;
                scan_next  = scan_reg + 1'b1;
            end
            ST_COMMIT:
            begin
                state_next = ST_SCAN_RD;
                scan_next  = '0;
            end
            ST_SUM:
            begin
                if (scan_reg >= (JOB_W+1)'(eff_jobs))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_LOAD;
            scan_reg          <= '0;
            job_count_reg     <= CFG_W'(MAX_JOBS);
            machine_count_reg <= CFG_W'(MAX_MACHINES);
            drop_reg          <= 1'b0;
            found_reg         <= 1'b0;
            sum_reg           <= '0;
            out_valid_reg     <= 1'b0;
            for (int i = 0; i < MAX_JOBS; i++)
            begin
                ops_loaded_reg[i] <= '0;
                next_op_reg[i]    <= '0;
                job_finish_reg[i] <= '0;
            end
            for (int i = 0; i < MAX_MACHINES; i++)
            begin
                machine_free_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_JOB_COUNT)
                begin
                    job_count_reg <= cfg_data;
                end
                else if (cfg_index == REG_MACHINE_COUNT)
                begin
                    machine_count_reg <= cfg_data;
                end
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    found_reg <= 1'b0;
                    sum_reg   <= '0;
                    if (in_fire)
                    begin
                        if (load_ok)
                        begin
                            ops_loaded_reg[in.job_id] <= ops_loaded_reg[in.job_id] + 1'b1;
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                        end
                    end
                end
                ST_SCAN_EVAL:
                begin
                    if (!found_reg || fin < best_reg)
                    begin
                        found_reg     <= 1'b1;
                        best_reg      <= fin;
                        best_job_reg  <= sj;
                        best_mach_reg <= rd_mach;
                    end
                end
                ST_COMMIT:
                begin
                    found_reg                       <= 1'b0;
                    machine_free_reg[best_mach_reg] <= best_reg;
                    job_finish_reg[best_job_reg]    <= best_reg;
                    next_op_reg[best_job_reg]       <= next_op_reg[best_job_reg] + 1'b1;
                end
                ST_SUM:
                begin
                    if (scan_reg < (JOB_W+1)'(eff_jobs))
                    begin
                        sum_reg <= sum_wide[SUM_WIDTH] ? SUM_MAX : sum_wide[SUM_WIDTH-1:0];
                    end
                    else
                    begin
                        out_reg.total_completion <= sum_reg;
                        out_reg.dropped          <= drop_reg;
                        out_valid_reg            <= 1'b1;
                        drop_reg                 <= 1'b0;
                        for (int i = 0; i < MAX_JOBS; i++)
                        begin
                            ops_loaded_reg[i] <= '0;
                            next_op_reg[i]    <= '0;
                            job_finish_reg[i] <= '0;
                        end
                        for (int i = 0; i < MAX_MACHINES; i++)
                        begin
                            machine_free_reg[i] <= '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out       = out_reg;

endmodule

### rtl/gjsd_checker.sv
// Port-level checks for the greedy job-shop dispatcher, bound to the top level.
// Depends on gjsd_pkg.
module gjsd_checker
    import gjsd_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input op_in_t  in,
    input logic    out_valid,
    input logic    out_ready,
    input result_t out
);

    // hold the result beat until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out))
        else $error("result beat changed while stalled");

    // no load while a result waits
    a_no_in_with_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");

    // last beat closes loading
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in.last_op |=> !in_ready)
        else $error("ready after last operation");

    // result never appears straight after an ordinary load beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in.last_op |=> !out_valid)
        else $error("result without last operation");

endmodule

bind greedy_job_shop_dispatcher gjsd_checker u_gjsd_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .in(in),
    .out_valid(out_valid), .out_ready(out_ready), .out(out));
